>>> design/fsft_pkg.sv
// Shared types, constants and register indexes of the fixed-step frame timer.
package fsft_pkg;

   localparam int unsigned TICKS_PER_SECOND_DEF = 10000000;
   localparam int unsigned MAX_UPDATES = 64;
   localparam int unsigned UPD_W = $clog2(MAX_UPDATES);

   localparam int unsigned COUNTER_W = 64;
   localparam int unsigned STEP_W = 24;
   localparam int unsigned LEFT_W = 32;
   localparam int unsigned FRAME_W = 32;
   localparam int unsigned FREQ_W = 34;
   localparam int unsigned MAXD_W = 30;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 34;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED_STEP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTER_FREQUENCY = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DELTA = 2'd3;

   localparam logic [STEP_W-1:0] TARGET_TICKS_RST = 24'd166666;
   localparam logic [FREQ_W-1:0] COUNTER_FREQUENCY_RST = 34'd10000000;
   localparam logic [MAXD_W-1:0] MAX_DELTA_RST = 30'd1000000;

   localparam int unsigned DIV_W = 64;
   localparam int unsigned DIVISOR_W = 34;
   localparam int unsigned DIV_STEPS = DIV_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic                 mode;
      logic [COUNTER_W-1:0] counter_now;
   } req_type;

   typedef struct packed {
      logic                 run_update;
      logic [STEP_W-1:0]    elapsed_ticks;
      logic [COUNTER_W-1:0] total_ticks;
      logic [FRAME_W-1:0]   frame_count;
      logic [FRAME_W-1:0]   frames_per_second;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_W-1:0]     quotient;
      logic [DIVISOR_W-1:0] remainder;
   } div_rsp_type;

endpackage

>>> design/fsft_div.sv
// Radix-2 restoring divider shared by the tick conversion and the modulo steps.
module fsft_div (
   input  logic                clock,
   input  logic                reset,
   input  fsft_pkg::div_req_type div_req,
   output fsft_pkg::div_rsp_type div_rsp
);
   import fsft_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W+1:0] trial;

   assign shifted = {rem_ff, quot_ff[DIV_W-1]};
   assign trial = {1'b0, shifted} - {2'b00, divisor_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         count_in = '0;
         quot_in = div_req.dividend;
         rem_in = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (trial[DIVISOR_W+1]) begin
            rem_in = shifted[DIVISOR_W-1:0];
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
         end
         quot_in = {quot_ff[DIV_W-2:0], ~trial[DIVISOR_W+1]};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quot_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> design/fixed_step_frame_timer_unit.sv
// Fixed-step frame timer: one transaction at a time through a shared 64-step divider.
// A reset-timing transaction goes from idle to the status state, which loads its status result.
// A tick multiplies its clamped counter difference and divides it to ticks before its
// first result, then gives one update step per cycle while the output is not stalled;
// a leftover modulo and a second-counter modulo through the divider follow when needed.
// Synchronous reset clears the timing state and loads the register defaults.
module fixed_step_frame_timer_unit #(
   parameter int unsigned TICKS_PER_SECOND = fsft_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fsft_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fsft_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fsft_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fsft_pkg::CSR_DATA_W-1:0]     csr_data
);
   import fsft_pkg::*;

   localparam int unsigned TPS_W = $clog2(TICKS_PER_SECOND + 1);
   localparam int unsigned PROD_W = MAXD_W + TPS_W;
   localparam logic [TPS_W-1:0] TPS = TPS_W'(TICKS_PER_SECOND);
   localparam logic [STEP_W:0] SNAP_WIN = (STEP_W + 1)'(TICKS_PER_SECOND / 4000);

   localparam int unsigned ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
   localparam logic [ST_W-1:0] ST_MUL = 4'd1;
   localparam logic [ST_W-1:0] ST_CONV = 4'd2;
   localparam logic [ST_W-1:0] ST_SNAP = 4'd3;
   localparam logic [ST_W-1:0] ST_EMIT = 4'd4;
   localparam logic [ST_W-1:0] ST_LCHK = 4'd5;
   localparam logic [ST_W-1:0] ST_LMOD = 4'd6;
   localparam logic [ST_W-1:0] ST_LATCH = 4'd7;
   localparam logic [ST_W-1:0] ST_SMOD = 4'd8;
   localparam logic [ST_W-1:0] ST_STATUS = 4'd9;

   logic [ST_W-1:0]      state_ff, state_in;
   logic                 fixed_ff, fixed_in;
   logic [STEP_W-1:0]    target_ff, target_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [MAXD_W-1:0]    maxd_ff, maxd_in;

   logic [COUNTER_W-1:0] last_counter_ff, last_counter_in;
   logic [COUNTER_W-1:0] second_ff, second_in;
   logic [LEFT_W-1:0]    leftover_ff, leftover_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [COUNTER_W-1:0] sum_ff, sum_in;
   logic [FRAME_W-1:0]   frames_ff, frames_in;
   logic [FRAME_W-1:0]   fts_ff, fts_in;
   logic [FRAME_W-1:0]   rate_ff, rate_in;

   logic [MAXD_W-1:0]    diff_ff, diff_in;
   logic [STEP_W-1:0]    delta_ff, delta_in;
   logic [UPD_W-1:0]     upd_ff, upd_in;
   logic                 any_ff, any_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_load;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic [STEP_W-1:0]    target_eff;
   logic [FREQ_W-1:0]    freq_eff;
   logic [COUNTER_W-1:0] raw_diff;
   logic [PROD_W-1:0]    prod;
   logic [STEP_W:0]      snap_diff;
   logic [STEP_W:0]      snap_abs;
   logic [STEP_W-1:0]    delta_snap;
   logic [LEFT_W-1:0]    left_sub;
   logic                 left_ge;
   logic                 sub_ge;
   logic                 out_free;
   logic [FRAME_W-1:0]   fts_next;

   fsft_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign target_eff = (target_ff == '0) ? STEP_W'(1) : target_ff;
   assign freq_eff = (freq_ff == '0) ? FREQ_W'(1) : freq_ff;
   assign raw_diff = req_data.counter_now - last_counter_ff;
   assign prod = PROD_W'(diff_ff) * PROD_W'(TPS);
   assign snap_diff = {1'b0, delta_ff} - {1'b0, target_eff};
   assign snap_abs = snap_diff[STEP_W] ? (~snap_diff + 1'b1) : snap_diff;
   assign delta_snap = (snap_abs < SNAP_WIN) ? target_eff : delta_ff;
   assign left_ge = leftover_ff >= LEFT_W'(target_eff);
   assign left_sub = leftover_ff - LEFT_W'(target_eff);
   assign sub_ge = left_sub >= LEFT_W'(target_eff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fts_next = fts_ff + FRAME_W'(any_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      fixed_in = fixed_ff;
      target_in = target_ff;
      freq_in = freq_ff;
      maxd_in = maxd_ff;
      last_counter_in = last_counter_ff;
      second_in = second_ff;
      leftover_in = leftover_ff;
      step_in = step_ff;
      sum_in = sum_ff;
      frames_in = frames_ff;
      fts_in = fts_ff;
      rate_in = rate_ff;
      diff_in = diff_ff;
      delta_in = delta_ff;
      upd_in = upd_ff;
      any_in = any_ff;
      rsp_load = 1'b0;
      rsp_in = rsp_ff;
      div_req.start = 1'b0;
      div_req.dividend = '0;
      div_req.divisor = freq_eff;

      if (csr_valid) begin
         case (csr_index)
            CSR_FIXED_STEP:        fixed_in = csr_data[0];
            CSR_TARGET_TICKS:      target_in = csr_data[STEP_W-1:0];
            CSR_COUNTER_FREQUENCY: freq_in = csr_data[FREQ_W-1:0];
            CSR_MAX_DELTA:         maxd_in = csr_data[MAXD_W-1:0];
            default:               fixed_in = fixed_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_counter_in = req_data.counter_now;
               if (req_data.mode) begin
                  leftover_in = '0;
                  rate_in = '0;
                  fts_in = '0;
                  second_in = '0;
                  state_in = ST_STATUS;
               end else begin
                  second_in = second_ff + raw_diff;
                  if (raw_diff > COUNTER_W'(maxd_ff)) begin
                     diff_in = maxd_ff;
                  end else begin
                     diff_in = raw_diff[MAXD_W-1:0];
                  end
                  upd_in = '0;
                  any_in = 1'b0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            div_req.start = 1'b1;
            div_req.dividend = DIV_W'(prod);
            state_in = ST_CONV;
         end
         ST_CONV: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient[DIV_W-1:STEP_W] != '0) begin
                  delta_in = '1;
               end else begin
                  delta_in = div_rsp.quotient[STEP_W-1:0];
               end
               state_in = ST_SNAP;
            end
         end
         ST_SNAP: begin
            if (fixed_ff) begin
               delta_in = delta_snap;
               leftover_in = leftover_ff + LEFT_W'(delta_snap);
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (fixed_ff) begin
               if (!left_ge) begin
                  state_in = ST_LCHK;
               end else if (out_free) begin
                  step_in = target_eff;
                  sum_in = sum_ff + COUNTER_W'(target_eff);
                  leftover_in = left_sub;
                  frames_in = frames_ff + 1'b1;
                  upd_in = upd_ff + 1'b1;
                  any_in = 1'b1;
                  rsp_load = 1'b1;
                  rsp_in.run_update = 1'b1;
                  rsp_in.elapsed_ticks = target_eff;
                  rsp_in.total_ticks = sum_in;
                  rsp_in.frame_count = frames_in;
                  rsp_in.frames_per_second = rate_ff;
                  rsp_in.last = !sub_ge || (upd_ff == UPD_W'(MAX_UPDATES - 1));
                  if (rsp_in.last) begin
                     state_in = ST_LCHK;
                  end
               end
            end else if (out_free) begin
               step_in = delta_ff;
               sum_in = sum_ff + COUNTER_W'(delta_ff);
               leftover_in = '0;
               frames_in = frames_ff + 1'b1;
               any_in = 1'b1;
               rsp_load = 1'b1;
               rsp_in.run_update = 1'b1;
               rsp_in.elapsed_ticks = delta_ff;
               rsp_in.total_ticks = sum_in;
               rsp_in.frame_count = frames_in;
               rsp_in.frames_per_second = rate_ff;
               rsp_in.last = 1'b1;
               state_in = ST_LCHK;
            end
         end
         ST_LCHK: begin
            if (left_ge) begin
               div_req.start = 1'b1;
               div_req.dividend = DIV_W'(leftover_ff);
               div_req.divisor = DIVISOR_W'(target_eff);
               state_in = ST_LMOD;
            end else begin
               state_in = ST_LATCH;
            end
         end
         ST_LMOD: begin
            if (div_rsp.done) begin
               leftover_in = div_rsp.remainder[LEFT_W-1:0];
               state_in = ST_LATCH;
            end
         end
         ST_LATCH: begin
            if (second_ff >= COUNTER_W'(freq_eff)) begin
               rate_in = fts_next;
               fts_in = '0;
               div_req.start = 1'b1;
               div_req.dividend = second_ff;
               state_in = ST_SMOD;
            end else begin
               fts_in = fts_next;
               state_in = any_ff ? ST_IDLE : ST_STATUS;
            end
         end
         ST_SMOD: begin
            if (div_rsp.done) begin
               second_in = COUNTER_W'(div_rsp.remainder);
               state_in = any_ff ? ST_IDLE : ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in.run_update = 1'b0;
               rsp_in.elapsed_ticks = step_ff;
               rsp_in.total_ticks = sum_ff;
               rsp_in.frame_count = frames_ff;
               rsp_in.frames_per_second = rate_ff;
               rsp_in.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fixed_ff <= 1'b0;
         target_ff <= TARGET_TICKS_RST;
         freq_ff <= COUNTER_FREQUENCY_RST;
         maxd_ff <= MAX_DELTA_RST;
         last_counter_ff <= '0;
         second_ff <= '0;
         leftover_ff <= '0;
         step_ff <= '0;
         sum_ff <= '0;
         frames_ff <= '0;
         fts_ff <= '0;
         rate_ff <= '0;
         upd_ff <= '0;
         any_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fixed_ff <= fixed_in;
         target_ff <= target_in;
         freq_ff <= freq_in;
         maxd_ff <= maxd_in;
         last_counter_ff <= last_counter_in;
         second_ff <= second_in;
         leftover_ff <= leftover_in;
         step_ff <= step_in;
         sum_ff <= sum_in;
         frames_ff <= frames_in;
         fts_ff <= fts_in;
         rate_ff <= rate_in;
         upd_ff <= upd_in;
         any_ff <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      diff_ff <= diff_in;
      delta_ff <= delta_in;
      rsp_ff <= rsp_in;
   end

   // A status result always closes its transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.run_update |-> rsp_ff.last)
      else $error("status result without last");

   // The divider is idle whenever a new transaction may be accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_rsp.busy && !div_rsp.done)
      else $error("divider active while idle");

   // Divider results only arrive while the sequencer waits for them.
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_CONV || state_ff == ST_LMOD || state_ff == ST_SMOD))
      else $error("unexpected divider result");

   // An accepted tick always starts the conversion in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.mode |=> div_req.start && state_ff == ST_MUL)
      else $error("tick did not start conversion");

endmodule
